### hdl/ila_pkg.sv
// ----------------------------------------------------------------------------
// ila_pkg: shared types and codes for the indexed list
// Operation and status codes, payload widths and the per-cell command.
// ----------------------------------------------------------------------------
package ila_pkg;

   localparam int DATA_W  = 32;
   localparam int MODE_W  = 3;
   localparam int INDEX_W = 10;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ     = 3'd0,
      MODE_INS_HEAD = 3'd1,
      MODE_INS_TAIL = 3'd2,
      MODE_INS_AT   = 3'd3,
      MODE_DELETE   = 3'd4
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Shift command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
   } cell_cmd_type;

endpackage

### hdl/ila_req_if.sv
// ----------------------------------------------------------------------------
// ila_req_if: request channel
// Valid/ready channel carrying one list operation per item.
// ----------------------------------------------------------------------------
interface ila_req_if;
   import ila_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [INDEX_W-1:0] index;
   logic signed [DATA_W-1:0]  value;

   modport source (output valid, output mode, output index, output value, input ready);
   modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

### hdl/ila_rsp_if.sv
// ----------------------------------------------------------------------------
// ila_rsp_if: response channel
// Valid/ready channel carrying one result per list operation.
// ----------------------------------------------------------------------------
interface ila_rsp_if;
   import ila_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic                     read_valid;
   logic [STAT_W-1:0]        status;
   logic [COUNT_W-1:0]       entry_count;

   modport source (output valid, output read_value, output read_valid, output status,
                   output entry_count, input ready);
   modport sink   (input valid, input read_value, input read_valid, input status,
                   input entry_count, output ready);
endinterface

### hdl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: bounded ordered list with insert and delete
// A row of CAPACITY cells holds the list; inserts shift the tail up one cell
// and deletes shift it down one cell, all cells in parallel. Reads go back through
// a registered four-way OR tree.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_ch   in   valid/ready    mode, index, value
//  rsp_ch   out  valid/ready    read_value, read_valid, status, entry_count
//
//  An item's cells and read address load at the accept edge; its read then
//  passes through the registered levels of the read tree and into the output
//  register. The next item is taken only once that result has entered the
//  output register, so only one item is ever in the tree.
//  A new item is taken while a result waits; its own result holds at the root.
//  Reset clears the count and control state; cell contents stay undefined.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
   parameter int CAPACITY = 256
) (
   input  logic       clock,
   input  logic       reset,
   ila_req_if.sink    req_ch,
   ila_rsp_if.source  rsp_ch
);
   import ila_pkg::*;

   localparam int CW     = $clog2(CAPACITY + 1);        // count width
   localparam int PW     = $clog2(CAPACITY);            // position width
   localparam int CMPW   = (CW > INDEX_W - 1) ? CW : INDEX_W - 1;
   localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
   localparam int WW     = $clog2(LEVELS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
   localparam logic [WW-1:0] WAIT_DONE  = WW'(LEVELS);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_WAIT = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [WW-1:0]          wait_ff, wait_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [PW-1:0]          rd_pos_ff;
   logic                   rd_ok_ff, rd_ok_in;
   status_type             stat_ff, stat_in;
   logic [COUNT_W-1:0]     cnt_ff;

   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic                   rsp_rd_ok_ff;
   status_type             rsp_stat_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   logic                   accept;
   logic                   done;
   logic                   idx_neg;
   logic [CMPW-1:0]        idx_ext;
   logic [CMPW-1:0]        cnt_ext;
   logic                   in_list;
   logic                   beyond;
   logic                   full;
   logic                   do_ins;
   logic                   do_del;
   logic [PW-1:0]          op_pos;
   cell_cmd_type           cmd;

   logic [DATA_W-1:0]      cell_data [CAPACITY];
   logic [DATA_W-1:0]      cell_rd   [CAPACITY];
   logic [DATA_W-1:0]      tree_root;

   // Take a new item whenever no item is in flight
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // Decode the operation against the current count
   assign idx_neg = req_ch.index[INDEX_W-1];
   assign idx_ext = CMPW'(req_ch.index[INDEX_W-2:0]);
   assign cnt_ext = CMPW'(count_ff);
   assign in_list = !idx_neg && (idx_ext < cnt_ext);
   assign beyond  = !idx_neg && (idx_ext > cnt_ext);
   assign full    = (count_ff == FULL_COUNT);

   always_comb begin
      do_ins   = 1'b0;
      do_del   = 1'b0;
      op_pos   = '0;
      rd_ok_in = 1'b0;
      stat_in  = ST_DONE;
      unique case (req_ch.mode)
         MODE_READ: begin
            if (in_list) begin
               rd_ok_in = 1'b1;
            end else begin
               stat_in = ST_RANGE;
            end
         end
         MODE_INS_HEAD: begin
            if (full) begin
               stat_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         MODE_INS_TAIL: begin
            if (full) begin
               stat_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
               op_pos = count_ff[PW-1:0];
            end
         end
         MODE_INS_AT: begin
            // out-of-range check wins over the full check
            if (beyond) begin
               stat_in = ST_RANGE;
            end else if (full) begin
               stat_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
               op_pos = idx_neg ? '0 : idx_ext[PW-1:0];
            end
         end
         MODE_DELETE: begin
            if (in_list) begin
               do_del = 1'b1;
               op_pos = idx_ext[PW-1:0];
            end else begin
               stat_in = ST_RANGE;
            end
         end
         default: begin
            // unused modes: no change, status done
         end
      endcase
   end

   assign cmd.ins = accept && do_ins;
   assign cmd.del = accept && do_del;

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Row of cells; the ends see zero from the missing neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ila_cell #(
         .POS_W (PW),
         .POS   (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (op_pos),
         .value      (req_ch.value),
         .left_data  (left_data),
         .right_data (right_data),
         .rd_pos     (rd_pos_ff),
         .data_out   (cell_data[i]),
         .rd_out     (cell_rd[i])
      );
   end

   ila_or_tree #(
      .LEAVES (CAPACITY),
      .LEVELS (LEVELS)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_rd),
      .root  (tree_root)
   );

   // Advance the wait counter until the tree root is settled, then hand the
   // result over once the output register is free
   assign done = (state_ff == S_WAIT) && (wait_ff == WAIT_DONE)
                 && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WAIT;
               wait_in  = '0;
            end
         end
         S_WAIT: begin
            if (wait_ff != WAIT_DONE) begin
               wait_in = wait_ff + WW'(1);
            end
            if (done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the per-item result fields while the read goes through the tree
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_pos_ff <= idx_ext[PW-1:0];
         rd_ok_ff  <= rd_ok_in;
         stat_ff   <= stat_in;
         cnt_ff    <= COUNT_W'(count_in);
      end
      if (done) begin
         rsp_value_ff <= rd_ok_ff ? tree_root : '0;
         rsp_rd_ok_ff <= rd_ok_ff;
         rsp_stat_ff  <= stat_ff;
         rsp_count_ff <= cnt_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.read_valid  = rsp_rd_ok_ff;
   assign rsp_ch.status      = rsp_stat_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
endmodule

### hdl/ila_cell.sv
// ----------------------------------------------------------------------------
// ila_cell: one list slot
// Holds one entry; on insert or delete it shifts against its neighbors by
// comparing its own position with the target position. Drives its entry onto
// the read tree when its position is selected.
// ----------------------------------------------------------------------------
module ila_cell #(
   parameter int POS_W = 8,
   parameter int POS   = 0
) (
   input  logic                        clock,
   input  ila_pkg::cell_cmd_type       cmd,
   input  logic [POS_W-1:0]            pos,
   input  logic [ila_pkg::DATA_W-1:0]  value,
   input  logic [ila_pkg::DATA_W-1:0]  left_data,
   input  logic [ila_pkg::DATA_W-1:0]  right_data,
   input  logic [POS_W-1:0]            rd_pos,
   output logic [ila_pkg::DATA_W-1:0]  data_out,
   output logic [ila_pkg::DATA_W-1:0]  rd_out
);
   import ila_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (MY_POS > pos) begin
            data_in = left_data;
         end else if (MY_POS == pos) begin
            data_in = value;
         end
      end else if (cmd.del) begin
         if (MY_POS >= pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_out   = (rd_pos == MY_POS) ? data_ff : '0;
endmodule

### hdl/ila_or_tree.sv
// ----------------------------------------------------------------------------
// ila_or_tree: registered read-back tree
// Four-way OR reduction of the masked cell outputs, one register per level.
// ----------------------------------------------------------------------------
module ila_or_tree #(
   parameter int LEAVES = 4,
   parameter int LEVELS = 1
) (
   input  logic                        clock,
   input  logic [ila_pkg::DATA_W-1:0]  leaf [LEAVES],
   output logic [ila_pkg::DATA_W-1:0]  root
);
   import ila_pkg::*;

   localparam int SPAN = 4 ** LEVELS;

   logic [DATA_W-1:0] node [LEVELS+1][SPAN];

   for (genvar j = 0; j < SPAN; j++) begin : g_leaf
      if (j < LEAVES) begin : g_used
         assign node[0][j] = leaf[j];
      end else begin : g_pad
         assign node[0][j] = '0;
      end
   end

   for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_level
      for (genvar j = 0; j < SPAN; j++) begin : g_node
         if (j < (SPAN >> (2 * lv))) begin : g_live
            always_ff @(posedge clock) begin
               node[lv][j] <= node[lv-1][4*j]   | node[lv-1][4*j+1] |
                              node[lv-1][4*j+2] | node[lv-1][4*j+3];
            end
         end else begin : g_idle
            always_ff @(posedge clock) begin
               node[lv][j] <= '0;
            end
         end
      end
   end

   assign root = node[LEVELS][0];
endmodule

### verif/indexed_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_tb: self-checking bench for the indexed list
// Drives list operations through the request channel, mirrors the list in a
// shadow copy to predict every result, and checks each response in order.
// A directed opening hits the corner cases; random traffic then swings the
// list between empty and full under several idle and stall patterns.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_tb;
   import ila_pkg::*;

   localparam int LIST_CAP    = 256;
   localparam int CYCLE_LIMIT = 500000;  // far above the slowest legal run
   localparam int REPORT_CAP  = 40;      // mismatch reports before going quiet
   localparam int PHASE_ITEMS = 325;
   localparam int DRAIN_WAIT  = 16;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     read_valid;
      status_type               status;
      logic [COUNT_W-1:0]       entry_count;
   } list_result_type;

   // Shadow of the list: applies each accepted item and queues its result.
   class list_shadow;
      logic signed [DATA_W-1:0] cells [LIST_CAP];
      int              used;
      list_result_type awaited_results [$];
      int              errors;
      int              taken, checked;
      int              read_hits, range_rejects, full_drops;
      int              full_events, empty_events;

      function new();
         used = 0;
         errors = 0;
         taken = 0;
         checked = 0;
         read_hits = 0;
         range_rejects = 0;
         full_drops = 0;
         full_events = 0;
         empty_events = 0;
      endfunction

      // Shift the tail up one place and drop v in at pos.
      function void place_at(int pos, logic signed [DATA_W-1:0] v);
         for (int p = used; p > pos; p--) cells[p] = cells[p-1];
         cells[pos] = v;
         used++;
      endfunction

      function void take_request(logic [MODE_W-1:0] mode, logic signed [INDEX_W-1:0] index,
                                 logic signed [DATA_W-1:0] value);
         list_result_type r;
         int              idx;
         int              prev;
         bit              in_list;
         idx     = index;
         prev    = used;
         in_list = (idx >= 0) && (idx < used);
         r       = '0;
         r.status = ST_DONE;
         case (mode)
            MODE_READ: begin
               if (in_list) begin
                  r.read_value = cells[idx];
                  r.read_valid = 1'b1;
               end else begin
                  r.status = ST_RANGE;
               end
            end
            MODE_INS_HEAD: begin
               if (used >= LIST_CAP) r.status = ST_FULL;
               else place_at(0, value);
            end
            MODE_INS_TAIL: begin
               if (used >= LIST_CAP) r.status = ST_FULL;
               else place_at(used, value);
            end
            MODE_INS_AT: begin
               // range is tested before fullness; a negative index means head
               if (idx >= 0 && idx > used) r.status = ST_RANGE;
               else if (used >= LIST_CAP) r.status = ST_FULL;
               else place_at((idx < 0) ? 0 : idx, value);
            end
            MODE_DELETE: begin
               if (in_list) begin
                  for (int p = idx; p < used - 1; p++) cells[p] = cells[p+1];
                  used--;
               end else begin
                  r.status = ST_RANGE;
               end
            end
            default: ;  // spare modes change nothing
         endcase
         r.entry_count = COUNT_W'(used);
         if (r.read_valid) read_hits++;
         if (r.status == ST_RANGE) range_rejects++;
         if (r.status == ST_FULL) full_drops++;
         if (used == LIST_CAP && prev != LIST_CAP) full_events++;
         if (used == 0 && prev != 0) empty_events++;
         taken++;
         awaited_results.push_back(r);
      endfunction

      function void flag(string field, longint exp_v, longint act_v);
         errors++;
         if (errors <= REPORT_CAP)
            $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
      endfunction

      function void match_result(list_result_type act);
         list_result_type exp;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP) $error("result arrived with nothing outstanding");
            return;
         end
         exp = awaited_results.pop_front();
         checked++;
         if (act.read_value !== exp.read_value)
            flag("read_value", exp.read_value, act.read_value);
         if (act.read_valid !== exp.read_valid)
            flag("read_valid", exp.read_valid, act.read_valid);
         if (act.status !== exp.status)
            flag("status", exp.status, act.status);
         if (act.entry_count !== exp.entry_count)
            flag("entry_count", exp.entry_count, act.entry_count);
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   idle_pct;    // sender: chance per cycle of holding valid low
   int   stall_pct;   // receiver: chance per cycle of holding ready low

   ila_req_if req_if ();
   ila_rsp_if rsp_if ();

   list_shadow shadow;

   indexed_list_insert_delete #(
      .CAPACITY (LIST_CAP)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Clock: 4 time units, two high, two low.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: end the run if it hangs anywhere.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("indexed_list_insert_delete regression: fail");
         $finish;
      end
   end

   // Present one item and hold it until accepted; idle first at random.
   // The previous item's accept edge is the only place valid may drop, so
   // valid gets at most one assignment per step.
   task automatic send_item(logic [MODE_W-1:0] mode, logic signed [INDEX_W-1:0] index,
                            logic signed [DATA_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode  <= mode;
      req_if.index <= index;
      req_if.value <= value;
      do @(posedge clock); while (!req_if.ready);
      shadow.take_request(mode, index, value);
   endtask

   // Random item generator state: grow toward full, then shrink to empty.
   bit growing;
   int full_tries;

   task automatic pick_item(output logic [MODE_W-1:0] mode,
                            output logic signed [INDEX_W-1:0] index,
                            output logic signed [DATA_W-1:0] value);
      int roll;
      int n;
      n = shadow.used;
      // flip to shrinking once six picks have found the list full, and back at empty
      if (growing && n == LIST_CAP) full_tries++;
      if (growing && full_tries >= 6) begin
         growing = 1'b0;
         full_tries = 0;
      end
      if (!growing && n == 0) growing = 1'b1;

      roll  = $urandom_range(0, 99);
      value = $urandom();
      if (roll < 10) begin
         // noise: any mode, any index bit pattern
         mode  = MODE_W'($urandom_range(0, 7));
         index = INDEX_W'($urandom_range(0, 1023));
      end else if (roll < 20) begin
         mode  = MODE_READ;
         index = (n > 0) ? INDEX_W'($urandom_range(0, n - 1)) : INDEX_W'($urandom_range(0, 3));
      end else if ((growing && roll < 30) || (!growing && roll >= 28)) begin
         mode  = MODE_DELETE;
         index = (n > 0) ? INDEX_W'($urandom_range(0, n - 1)) : INDEX_W'($urandom_range(0, 3));
      end else begin
         case ($urandom_range(0, 2))
            0:       mode = MODE_INS_HEAD;
            1:       mode = MODE_INS_TAIL;
            default: mode = MODE_INS_AT;
         endcase
         case ($urandom_range(0, 9))
            0:       index = -INDEX_W'($urandom_range(1, 512));  // negative goes to head
            1:       index = INDEX_W'(n);                        // append at count
            default: index = INDEX_W'($urandom_range(0, n));
         endcase
      end
   endtask

   // Receiver: check every accepted result, then choose ready for next cycle.
   initial begin
      list_result_type act;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_if.valid && rsp_if.ready) begin
            act.read_value  = rsp_if.read_value;
            act.read_valid  = rsp_if.read_valid;
            act.status      = status_type'(rsp_if.status);
            act.entry_count = rsp_if.entry_count;
            shadow.match_result(act);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         @(posedge clock);
      end
   end

   // Main sequence.
   initial begin
      logic [MODE_W-1:0]         m;
      logic signed [INDEX_W-1:0] ix;
      logic signed [DATA_W-1:0]  v;
      int                        idle_tab  [4];
      int                        stall_tab [4];

      shadow     = new();
      growing    = 1'b1;
      full_tries = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      idle_tab   = '{0, 66, 0, 12};
      stall_tab  = '{0, 0, 66, 12};

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.mode  <= MODE_READ;
      req_if.index <= '0;
      req_if.value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list corners, each insert flavor, value extremes
      send_item(MODE_READ,     10'sd0, 32'sd0);                // bad read on empty
      send_item(MODE_DELETE,   10'sd0, 32'sd0);                // bad delete on empty
      send_item(MODE_INS_AT,   10'sd1, 32'sd5);                // beyond count: ignored
      send_item(MODE_INS_AT,   10'sd0, 32'sh7FFF_FFFF);        // at count: append
      send_item(MODE_INS_HEAD, 10'sd0, 32'sh8000_0000);
      send_item(MODE_INS_TAIL, 10'sd0, -32'sd1);               // -1 is a legal entry
      send_item(MODE_INS_AT,   -10'sd1, 32'sd0);               // negative index: head
      send_item(MODE_INS_AT,   10'sd2, 32'sh1234_5678);        // middle
      send_item(MODE_INS_AT,   10'sd5, 32'shA5A5_A5A5);        // at count again
      send_item(MODE_INS_AT,   10'sh200, 32'sh5A5A_5A5A);      // most negative index
      send_item(MODE_INS_AT,   10'sh1FF, 32'sd7);              // largest index: ignored
      send_item(MODE_READ,     10'sd0, 32'sd0);
      send_item(MODE_READ,     10'sd6, 32'sd0);                // last entry
      send_item(MODE_READ,     10'sd7, 32'sd0);                // at count: bad
      send_item(MODE_READ,     -10'sd1, 32'sd0);
      send_item(MODE_READ,     10'sh1FF, 32'sd0);
      send_item(MODE_READ,     10'sh200, 32'sd0);
      send_item(MODE_READ,     10'sd256, 32'sd0);
      for (int k = MODE_DELETE + 1; k < 8; k++)
         send_item(MODE_W'(k), 10'sh3FF, 32'shFFFF_FFFF);      // spare modes
      send_item(MODE_DELETE,   -10'sd1, 32'sd0);
      send_item(MODE_DELETE,   10'sd7, 32'sd0);                // at count: bad
      send_item(MODE_DELETE,   10'sd6, 32'sd0);                // last entry
      send_item(MODE_DELETE,   10'sd0, 32'sd0);                // head
      send_item(MODE_DELETE,   10'sd2, 32'sd0);                // middle
      send_item(MODE_READ,     10'sd2, 32'sd0);

      // Random: fill-and-drain traffic under each idle/stall pattern
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_tab[ph];
         stall_pct = stall_tab[ph];
         repeat (PHASE_ITEMS) begin
            pick_item(m, ix, v);
            send_item(m, ix, v);
         end
      end
      req_if.valid <= 1'b0;

      // Drain: let every result in, then watch for strays
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d items and %0d results: %0d read hits, %0d range rejects,",
               shadow.taken, shadow.checked, shadow.read_hits, shadow.range_rejects);
      $display("  %0d inserts dropped at full, list filled %0d times and emptied %0d times",
               shadow.full_drops, shadow.full_events, shadow.empty_events);
      if (shadow.errors == 0 && shadow.outstanding() == 0) begin
         $display("indexed_list_insert_delete regression: pass");
      end else begin
         $display("indexed_list_insert_delete regression: fail");
      end
      $finish;
   end

endmodule
